// File: sv/coms_pkg.sv
// Shared types, widths, codes and helpers for the center-of-mass shift block.
package coms_pkg;

  // Field widths of the atom and result beats.
  localparam int MASS_W   = 24;
  localparam int POS_W    = 32;
  localparam int PROD_W   = 57;
  localparam int SUM_W    = 64;
  localparam int TMASS_W  = 31;
  localparam int IDX_W    = 6;
  localparam int STATUS_W = 2;

  // Packed stream payload widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 104;

  // Status codes carried on every result of a run.
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_MASS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED   = 2'd2;

  // Axis codes used to sequence the shared divider.
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // One stored atom position.
  typedef struct packed {
    logic signed [POS_W-1:0] z;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } coord_t;

  // Divider status as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Position minus center, computed on 33 bits and saturated to 32.
  function automatic logic signed [POS_W-1:0] sat_sub(
    input logic signed [POS_W-1:0] a,
    input logic signed [POS_W-1:0] b
  );
    logic signed [POS_W:0] diff;
    logic signed [POS_W-1:0] res;
    diff = {a[POS_W-1], a} - {b[POS_W-1], b};
    if (diff[POS_W] != diff[POS_W-1]) begin
      res = diff[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      res = diff[POS_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: sv/coms_store.sv
// Coordinate memory: one write port for loading, one registered read port for emitting.
module coms_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  coms_pkg::coord_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output coms_pkg::coord_t rdata
);
  import coms_pkg::*;

  coord_t mem [DEPTH];

  // Write on load.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; the data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/coms_accum.sv
// Mass-weighted position accumulators and total mass, with a registered multiply stage.
module coms_accum (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                clr,
  input  logic [coms_pkg::MASS_W-1:0]         mass,
  input  coms_pkg::coord_t                    pos,
  output logic signed [coms_pkg::SUM_W-1:0]   sum_x,
  output logic signed [coms_pkg::SUM_W-1:0]   sum_y,
  output logic signed [coms_pkg::SUM_W-1:0]   sum_z,
  output logic [coms_pkg::TMASS_W-1:0]        total,
  output logic                                busy
);
  import coms_pkg::*;

  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [PROD_W-1:0] prod_z;
  logic                     prod_valid;

  // Multiply stage: one product per axis, registered before accumulation.
  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= $signed({1'b0, mass}) * pos.x;
      prod_y <= $signed({1'b0, mass}) * pos.y;
      prod_z <= $signed({1'b0, mass}) * pos.z;
    end
  end

  // Accumulate stage and total mass.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      sum_x      <= '0;
      sum_y      <= '0;
      sum_z      <= '0;
      total      <= '0;
    end else begin
      prod_valid <= en;
      if (clr) begin
        sum_x <= '0;
        sum_y <= '0;
        sum_z <= '0;
        total <= '0;
      end else begin
        if (prod_valid) begin
          sum_x <= sum_x + SUM_W'(prod_x);
          sum_y <= sum_y + SUM_W'(prod_y);
          sum_z <= sum_z + SUM_W'(prod_z);
        end
        if (en) begin
          total <= total + TMASS_W'(mass);
        end
      end
    end
  end

  assign busy = prod_valid;

endmodule

// File: sv/coms_div.sv
// Restoring divider, one quotient bit per cycle, signed dividend truncated toward zero.
module coms_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [coms_pkg::SUM_W-1:0]   dividend,
  input  logic [coms_pkg::TMASS_W-1:0]        divisor,
  output coms_pkg::div_stat_t                 stat,
  output logic signed [coms_pkg::POS_W-1:0]   quotient
);
  import coms_pkg::*;

  localparam int CNT_W = $clog2(SUM_W);

  logic [SUM_W-1:0]   q;
  logic [TMASS_W-1:0] rem;
  logic [CNT_W-1:0]   cnt;
  logic               neg;
  logic               busy;
  logic               done;
  logic [TMASS_W:0]   trial;
  logic [TMASS_W:0]   diff;
  logic [POS_W:0]     mag;
  logic [POS_W:0]     signed_q;

  // Shift in the next dividend bit and try the subtraction.
  always_comb begin
    trial = {rem, q[SUM_W-1]};
    diff  = trial - {1'b0, divisor};
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: magnitude of the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      q   <= dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
      rem <= '0;
      cnt <= CNT_W'(SUM_W - 1);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (trial >= {1'b0, divisor}) begin
        rem <= diff[TMASS_W-1:0];
        q   <= {q[SUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[TMASS_W-1:0];
        q   <= {q[SUM_W-2:0], 1'b0};
      end
    end
  end

  // The mean fits in 32 bits, so 33 bits of magnitude carry the sign fix.
  always_comb begin
    mag      = q[POS_W:0];
    signed_q = neg ? ((POS_W+1)'(0) - mag) : mag;
  end

  assign quotient  = signed_q[POS_W-1:0];
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: sv/center_of_mass_shift.sv
// Top level of the center-of-mass shift block: load sequencing, division and emit.
//
// Atoms arrive on the s_axis channel, one per beat, mass and x, y, z packed in
// tdata and tlast marking the final atom of a molecule. Loading takes one beat
// per cycle while s_axis_tready is high. Up to MAX_ATOMS atoms are stored;
// further atoms are dropped and the run gets status 2 if its mass is nonzero.
// After the tlast beat, s_axis_tready stays low until the run is emitted. The
// multiply-accumulate pipeline drains first, then one shared restoring
// divider computes the x, y and z centers one after another, each by loading,
// developing 64 quotient bits and signalling done. A zero total mass skips
// the division and gives status 1 with positions unshifted.
// Results then leave on m_axis in load order, one per cycle unless the
// receiver stalls, read from the registered port of the coordinate memory,
// with tlast on the final atom and the status in tuser. A stalled receiver
// holds the output register and the memory read register; nothing is lost.
// s_axis_tready rises again as soon as the final result beat is in the output register.
// Reset is synchronous; it empties the accumulators and both channels. The
// coordinate memory is not cleared, since only entries of the current run are
// read.
module center_of_mass_shift #(
  parameter int MAX_ATOMS = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // atom_mass[23:0], pos_x[55:24], pos_y[87:56], pos_z[119:88]
  input  logic [coms_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // atom_index[5:0], shifted_x[37:6], shifted_y[69:38], shifted_z[101:70], zero pad
  output logic [coms_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast,
  // status[1:0]
  output logic [coms_pkg::STATUS_W-1:0]       m_axis_tuser
);
  import coms_pkg::*;

  localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CW = $clog2(MAX_ATOMS + 1);

  localparam logic [1:0] S_LOAD   = 2'd0;
  localparam logic [1:0] S_SETTLE = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0]               state;
  logic [CW-1:0]            count;
  logic                     overflow;
  logic [STATUS_W-1:0]      status;
  logic [1:0]               axis;
  logic                     div_start;
  logic signed [POS_W-1:0]  center_x;
  logic signed [POS_W-1:0]  center_y;
  logic signed [POS_W-1:0]  center_z;

  logic [CW-1:0]            rd_ptr;
  logic [CW-1:0]            rd_idx;
  logic                     rd_valid;
  logic                     rd_en;
  logic                     rd_last;
  logic                     out_load;
  logic                     run_end;

  logic                     in_accept;
  logic                     room;
  logic                     acc_en;
  logic [MASS_W-1:0]        in_mass;
  coord_t                   in_pos;
  coord_t                   rd_data;

  logic signed [SUM_W-1:0]  sum_x;
  logic signed [SUM_W-1:0]  sum_y;
  logic signed [SUM_W-1:0]  sum_z;
  logic [TMASS_W-1:0]       total;
  logic                     acc_busy;
  logic signed [SUM_W-1:0]  dividend;
  div_stat_t                div_stat;
  logic signed [POS_W-1:0]  quotient;

  logic [IDX_W-1:0]         out_index;
  logic signed [POS_W-1:0]  out_x;
  logic signed [POS_W-1:0]  out_y;
  logic signed [POS_W-1:0]  out_z;

  // Input beat unpacking and load decisions; x sits lowest, as in coord_t.
  assign in_mass   = s_axis_tdata[MASS_W-1:0];
  assign in_pos    = coord_t'(s_axis_tdata[MASS_W +: 3*POS_W]);
  assign s_axis_tready = (state == S_LOAD);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign room      = (count < CW'(MAX_ATOMS));
  assign acc_en    = in_accept && room;

  // Emit pipeline: memory read register feeds the output register.
  assign out_load = rd_valid && (!m_axis_tvalid || m_axis_tready);
  assign rd_en    = (state == S_EMIT) && (rd_ptr < count) && (!rd_valid || out_load);
  assign rd_last  = (rd_idx == count - CW'(1));
  assign run_end  = out_load && rd_last;

  coms_store #(
    .DEPTH (MAX_ATOMS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (acc_en),
    .waddr (count[AW-1:0]),
    .wdata (in_pos),
    .re    (rd_en),
    .raddr (rd_ptr[AW-1:0]),
    .rdata (rd_data)
  );

  coms_accum u_accum (
    .clk   (clk),
    .rst   (rst),
    .en    (acc_en),
    .clr   (run_end),
    .mass  (in_mass),
    .pos   (in_pos),
    .sum_x (sum_x),
    .sum_y (sum_y),
    .sum_z (sum_z),
    .total (total),
    .busy  (acc_busy)
  );

  // Select the weighted sum for the axis being divided.
  always_comb begin
    unique case (axis)
      AXIS_X:  dividend = sum_x;
      AXIS_Y:  dividend = sum_y;
      AXIS_Z:  dividend = sum_z;
      default: dividend = sum_x;
    endcase
  end

  coms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (total),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // Run sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      overflow  <= 1'b0;
      axis      <= AXIS_X;
      div_start <= 1'b0;
      rd_ptr    <= '0;
    end else begin
      div_start <= 1'b0;
      if (rd_en) begin
        rd_ptr <= rd_ptr + CW'(1);
      end
      unique case (state)
        S_LOAD: begin
          if (in_accept) begin
            if (room) begin
              count <= count + CW'(1);
            end else begin
              overflow <= 1'b1;
            end
            if (s_axis_tlast) begin
              state <= S_SETTLE;
            end
          end
        end
        S_SETTLE: begin
          if (!acc_busy) begin
            if (total == '0) begin
              state <= S_EMIT;
            end else begin
              axis      <= AXIS_X;
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            if (axis == AXIS_Z) begin
              state <= S_EMIT;
            end else begin
              axis      <= axis + 2'd1;
              div_start <= 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (run_end) begin
            state    <= S_LOAD;
            count    <= '0;
            overflow <= 1'b0;
            rd_ptr   <= '0;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Centers and run status.
  always_ff @(posedge clk) begin
    if (state == S_SETTLE && !acc_busy) begin
      if (total == '0) begin
        status   <= STATUS_ZERO_MASS;
        center_x <= '0;
        center_y <= '0;
        center_z <= '0;
      end else begin
        status <= overflow ? STATUS_DROPPED : STATUS_OK;
      end
    end else if (state == S_DIV && div_stat.done) begin
      unique case (axis)
        AXIS_X:  center_x <= quotient;
        AXIS_Y:  center_y <= quotient;
        AXIS_Z:  center_z <= quotient;
        default: center_x <= quotient;
      endcase
    end
  end

  // Read register tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (rd_en) begin
      rd_valid <= 1'b1;
    end else if (out_load) begin
      rd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx <= rd_ptr;
    end
  end

  // Output register: shift, saturate and hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index    <= IDX_W'(rd_idx);
      out_x        <= sat_sub(rd_data.x, center_x);
      out_y        <= sat_sub(rd_data.y, center_y);
      out_z        <= sat_sub(rd_data.z, center_z);
      m_axis_tlast <= rd_last;
      m_axis_tuser <= status;
    end
  end

  assign m_axis_tdata = {2'b00, out_z, out_y, out_x, out_index};

endmodule

// File: sv/coms_checker.sv
// Port-level assertions for the center-of-mass shift block, bound to the top level.
module coms_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              s_axis_tlast,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [coms_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                              m_axis_tlast,
  input logic [coms_pkg::STATUS_W-1:0]     m_axis_tuser
);
  import coms_pkg::*;

  // Reset empties the result channel.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result beat valid right after reset");

  // The final atom closes the load window until the run is emitted.
  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("atom beat accepted right after the final atom");

  // A stalled result beat keeps its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
       && $stable(m_axis_tuser)))
    else $error("stalled result beat changed");

  // Only defined status codes leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == STATUS_OK || m_axis_tuser == STATUS_ZERO_MASS
                       || m_axis_tuser == STATUS_DROPPED))
    else $error("undefined status code on a result beat");

endmodule

bind center_of_mass_shift coms_checker u_coms_checker (.*);

// File: dv/tb.sv
// Self-checking testbench for the center-of-mass shift block.
`timescale 1ns / 1ps

module tb;
  import coms_pkg::*;

  localparam int ATOM_CAP = 64;
  localparam int RANDOM_ITEMS = 470;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES = 400;

  localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFFFFFF;
  localparam logic signed [POS_W-1:0] POS_MIN = 32'sh80000000;
  localparam logic [MASS_W-1:0] MASS_MAX = 24'hFFFFFF;

  // One shifted atom as it leaves the block.
  typedef struct {
    logic [IDX_W-1:0] idx;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    logic last;
    logic [STATUS_W-1:0] status;
  } atom_result_t;

  // Tracks the molecule being loaded and the shifted atoms still owed by the block.
  class atom_scoreboard;
    coord_t loaded[$];
    longint sum_x, sum_y, sum_z, mass_sum;
    bit dropped;
    atom_result_t owed[$];
    int errors, molecules, atoms_in, shifted_seen, overflow_runs, zero_mass_runs;

    function int pending();
      return owed.size();
    endfunction

    function logic signed [POS_W-1:0] clamp32(longint v);
      if (v > 64'sd2147483647) return POS_MAX;
      if (v < -64'sd2147483648) return POS_MIN;
      return v[POS_W-1:0];
    endfunction

    // Called for every accepted atom; a final atom releases the whole shifted molecule.
    function void note_atom(logic [MASS_W-1:0] mass, logic signed [POS_W-1:0] x,
                            logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z,
                            logic last);
      longint cx, cy, cz;
      logic [STATUS_W-1:0] run_status;
      atom_result_t r;
      coord_t a;
      atoms_in++;
      if (loaded.size() < ATOM_CAP) begin
        a.x = x;
        a.y = y;
        a.z = z;
        loaded = {loaded, a};
        sum_x += longint'(mass) * longint'(x);
        sum_y += longint'(mass) * longint'(y);
        sum_z += longint'(mass) * longint'(z);
        mass_sum += longint'(mass);
      end else begin
        dropped = 1'b1;
      end
      if (!last) return;

      molecules++;
      if (dropped) overflow_runs++;
      cx = 0;
      cy = 0;
      cz = 0;
      // A weightless molecule is passed through unshifted; that status wins over drops.
      if (mass_sum == 0) begin
        run_status = STATUS_ZERO_MASS;
        zero_mass_runs++;
      end else begin
        cx = sum_x / mass_sum;
        cy = sum_y / mass_sum;
        cz = sum_z / mass_sum;
        run_status = dropped ? STATUS_DROPPED : STATUS_OK;
      end
      foreach (loaded[k]) begin
        r.idx = IDX_W'(k);
        r.x = clamp32(longint'($signed(loaded[k].x)) - cx);
        r.y = clamp32(longint'($signed(loaded[k].y)) - cy);
        r.z = clamp32(longint'($signed(loaded[k].z)) - cz);
        r.last = (k == loaded.size() - 1);
        r.status = run_status;
        owed = {owed, r};
      end
      loaded.delete();
      sum_x = 0;
      sum_y = 0;
      sum_z = 0;
      mass_sum = 0;
      dropped = 1'b0;
    endfunction

    function void check_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // Called for every accepted result beat.
    function void check_result(atom_result_t got);
      atom_result_t want;
      if (owed.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual atom_index %0d",
                 $time, got.idx);
        return;
      end
      want = owed.pop_front();
      shifted_seen++;
      check_field("atom_index", POS_W'(want.idx), POS_W'(got.idx));
      check_field("shifted_x", want.x, got.x);
      check_field("shifted_y", want.y, got.y);
      check_field("shifted_z", want.z, got.z);
      check_field("last_result", POS_W'(want.last), POS_W'(got.last));
      check_field("status", POS_W'(want.status), POS_W'(got.status));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic [STATUS_W-1:0] m_axis_tuser;

  logic [1:0] phase = 2'd0;
  int items_sent = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int cycle_count = 0;
  atom_scoreboard atom_sb = new();

  center_of_mass_shift #(
    .MAX_ATOMS(ATOM_CAP)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  always #1 clk = ~clk;

  // Idle rates per phase: receiver-heavy gaps, then sender-heavy, then none.
  function int sender_idle_pct();
    return (phase == 2'd0) ? 34 : (phase == 2'd1) ? 57 : 0;
  endfunction

  function int receiver_idle_pct();
    return (phase == 2'd0) ? 57 : (phase == 2'd1) ? 34 : 0;
  endfunction

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, atom_sb.pending());
      $display("FAILURE");
      $finish;
    end
  end

  // One long receiver hold-off in the last phase, counted in cycles.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && phase == 2'd2 && m_axis_tvalid) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Result side: check accepted beats and drive tready.
  always @(posedge clk) begin
    atom_result_t got;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.idx = m_axis_tdata[5:0];
        got.x = m_axis_tdata[37:6];
        got.y = m_axis_tdata[69:38];
        got.z = m_axis_tdata[101:70];
        got.last = m_axis_tlast;
        got.status = m_axis_tuser;
        atom_sb.check_result(got);
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct());
      end
    end
  end

  // Offers one atom beat, with random gaps ahead of it, and waits for acceptance.
  task automatic send_atom(input logic [MASS_W-1:0] mass, input logic signed [POS_W-1:0] x,
                           input logic signed [POS_W-1:0] y,
                           input logic signed [POS_W-1:0] z, input logic last);
    while ($urandom_range(99) < sender_idle_pct()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x, mass};
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    atom_sb.note_atom(mass, x, y, z, last);
    items_sent++;
  endtask

  function automatic logic [MASS_W-1:0] rand_mass();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return MASS_MAX;
    if (pick < 6) return MASS_W'($urandom_range(1, 24'h03FFFF));
    return MASS_W'($urandom);
  endfunction

  function automatic logic signed [POS_W-1:0] rand_pos();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return POS_MIN;
    if (pick == 1) return POS_MAX;
    if (pick == 2) return $signed($urandom_range(0, 2000)) - 1000;
    return $urandom;
  endfunction

  // A molecule of random atoms; the final one carries tlast.
  task automatic send_molecule(input int n_atoms, input bit weightless);
    logic [MASS_W-1:0] mass;
    for (int i = 0; i < n_atoms; i++) begin
      mass = weightless ? '0 : rand_mass();
      send_atom(mass, rand_pos(), rand_pos(), rand_pos(), i == n_atoms - 1);
    end
  endtask

  initial begin
    int pick;
    int n_atoms;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single weightless atom, single heavy atom at the extremes.
    send_atom('0, POS_MAX, POS_MIN, '0, 1'b1);
    send_atom(MASS_MAX, POS_MIN, POS_MAX, -1, 1'b1);
    // Heavy atom at one extreme, light one at the other: both saturation directions.
    send_atom(MASS_MAX, POS_MAX, POS_MIN, -1, 1'b0);
    send_atom(24'h000001, POS_MIN, POS_MAX, 1, 1'b1);
    // Negative weighted mean smaller than one LSB must truncate toward zero.
    send_atom(24'h010000, -1, 1, '0, 1'b0);
    send_atom(24'h020000, '0, '0, '0, 1'b1);
    // Several atoms, all weightless.
    send_atom('0, 1234, -5678, POS_MAX, 1'b0);
    send_atom('0, POS_MIN, '0, -1, 1'b0);
    send_atom('0, -1, POS_MAX, POS_MIN, 1'b1);
    // Alternating bit patterns on the mass, x and y fields.
    send_atom(24'hAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'hFFFFFFFF, 1'b0);
    send_atom(24'h555555, 32'hAAAAAAAA, 32'h55555555, 32'h00000001, 1'b0);
    send_atom(24'h000001, '0, '0, '0, 1'b0);
    send_atom(rand_mass(), rand_pos(), rand_pos(), rand_pos(), 1'b1);

    // Beyond capacity, with the final atom itself dropped; then a weightless overflow and an exactly full molecule.
    send_molecule(66, 1'b0);
    send_molecule(65, 1'b1);
    send_molecule(ATOM_CAP, 1'b0);

    // Random molecules, mostly small, with occasional full and overflowing ones.
    while (items_sent < RANDOM_ITEMS) begin
      phase <= (items_sent < 200) ? 2'd0 : (items_sent < 340) ? 2'd1 : 2'd2;
      pick = $urandom_range(99);
      if (pick < 5) n_atoms = $urandom_range(60, 70);
      else if (pick < 15) n_atoms = $urandom_range(9, 30);
      else n_atoms = $urandom_range(1, 8);
      send_molecule(n_atoms, $urandom_range(99) < 8);
    end
    s_axis_tvalid <= 1'b0;

    // Let the last molecule drain, then allow the block to settle.
    while (atom_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Loaded %0d atoms in %0d molecules and checked %0d shifted atoms.",
             atom_sb.atoms_in, atom_sb.molecules, atom_sb.shifted_seen);
    $display("Molecules over capacity: %0d, weightless molecules: %0d, errors: %0d.",
             atom_sb.overflow_runs, atom_sb.zero_mass_runs, atom_sb.errors);
    if (atom_sb.errors == 0 && atom_sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
